### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AST_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define AST_IMPL(label, clk, rst, ante, cons, msg)

`define AST_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg
// Constants, codes and the control store of the primitive assembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pa_pkg;

   localparam int SLOT_DEPTH = 32;
   localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
   localparam int POLY_CAP   = (SLOT_DEPTH < 32) ? SLOT_DEPTH : 32;
   localparam int FILL_W     = 6;
   localparam int SLOT_W     = 5;
   localparam int TAG_W      = 16;
   localparam int PC_W       = 5;
   localparam int ACT_W      = 3;

   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_VERTEX = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;
   localparam logic [1:0] OP_RSVD   = 2'd3;

   localparam logic [3:0] MODE_POINTS  = 4'd0;
   localparam logic [3:0] MODE_LINES   = 4'd1;
   localparam logic [3:0] MODE_LSTRIP  = 4'd2;
   localparam logic [3:0] MODE_LOOP    = 4'd3;
   localparam logic [3:0] MODE_TRIS    = 4'd4;
   localparam logic [3:0] MODE_TSTRIP  = 4'd5;
   localparam logic [3:0] MODE_FAN     = 4'd6;
   localparam logic [3:0] MODE_QUADS   = 4'd7;
   localparam logic [3:0] MODE_QSTRIP  = 4'd8;
   localparam logic [3:0] MODE_POLYGON = 4'd9;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SEQ = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;

   localparam logic [ACT_W-1:0] ACT_NOP   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ERR   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WRTAG = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RD    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_WR    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_RUN   = 3'd5;
   localparam logic [ACT_W-1:0] ACT_ONE   = 3'd6;

   // program entry points
   localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
   localparam logic [PC_W-1:0] PC_ERR   = 5'd1;
   localparam logic [PC_W-1:0] PC_VO    = 5'd2;
   localparam logic [PC_W-1:0] PC_VR    = 5'd3;
   localparam logic [PC_W-1:0] PC_LF    = 5'd5;
   localparam logic [PC_W-1:0] PC_LS    = 5'd8;
   localparam logic [PC_W-1:0] PC_FAN   = 5'd12;
   localparam logic [PC_W-1:0] PC_QS    = 5'd16;
   localparam logic [PC_W-1:0] PC_LE    = 5'd22;
   localparam logic [PC_W-1:0] PC_PE    = 5'd24;

   typedef struct packed {
      logic [ACT_W-1:0]   act;
      logic [SLOT_AW-1:0] addr;
      logic               last;
      logic               fin;
   } ctl_type;

   function automatic ctl_type mk(input logic [ACT_W-1:0] act, input int addr,
                                  input logic last, input logic fin);
      ctl_type w;
      w.act  = act;
      w.addr = SLOT_AW'(addr);
      w.last = last;
      w.fin  = fin;
      return w;
   endfunction

   function automatic ctl_type rom_word(input logic [PC_W-1:0] pc);
      ctl_type w;
      unique case (pc)
         5'd1:    w = mk(ACT_ERR,   0, 1'b1, 1'b1);
         5'd2:    w = mk(ACT_WRTAG, 0, 1'b0, 1'b1);
         5'd3:    w = mk(ACT_WRTAG, 0, 1'b0, 1'b0);
         5'd4:    w = mk(ACT_RUN,   0, 1'b0, 1'b1);
         5'd5:    w = mk(ACT_WRTAG, 0, 1'b0, 1'b0);
         5'd6:    w = mk(ACT_RD,    0, 1'b0, 1'b0);
         5'd7:    w = mk(ACT_WR,    2, 1'b0, 1'b1);
         5'd8:    w = mk(ACT_WRTAG, 0, 1'b0, 1'b0);
         5'd9:    w = mk(ACT_RUN,   0, 1'b0, 1'b0);
         5'd10:   w = mk(ACT_RD,    1, 1'b0, 1'b0);
         5'd11:   w = mk(ACT_WR,    0, 1'b0, 1'b1);
         5'd12:   w = mk(ACT_WRTAG, 0, 1'b0, 1'b0);
         5'd13:   w = mk(ACT_RUN,   0, 1'b0, 1'b0);
         5'd14:   w = mk(ACT_RD,    2, 1'b0, 1'b0);
         5'd15:   w = mk(ACT_WR,    1, 1'b0, 1'b1);
         5'd16:   w = mk(ACT_WRTAG, 0, 1'b0, 1'b0);
         5'd17:   w = mk(ACT_RUN,   0, 1'b0, 1'b0);
         5'd18:   w = mk(ACT_RD,    2, 1'b0, 1'b0);
         5'd19:   w = mk(ACT_WR,    0, 1'b0, 1'b0);
         5'd20:   w = mk(ACT_RD,    3, 1'b0, 1'b0);
         5'd21:   w = mk(ACT_WR,    1, 1'b0, 1'b1);
         5'd22:   w = mk(ACT_ONE,   0, 1'b0, 1'b0);
         5'd23:   w = mk(ACT_ONE,   2, 1'b1, 1'b1);
         5'd24:   w = mk(ACT_RUN,   0, 1'b0, 1'b1);
         default: w = mk(ACT_NOP,   0, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

### rtl/core/primitive_assembler.sv
// ----------------------------------------------------------------------------
// primitive_assembler
// Groups vertex tags into points, lines, triangles, quads and polygons and
// emits each finished primitive as a run of slot contents.
// ----------------------------------------------------------------------------
// Steps: a begin is taken in idle and sends no response; a vertex is accepted, then
// its tag is written to its slot, then each slot copy is a read and a write and each
// emitted slot a registered memory read and a response load; an error is accepted and
// then answered. One transaction at a time; a held response stalls the sequencer.
// Reset: synchronous, active high; no primitive open, fill and running count
// at zero, slot memory contents left as they are.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module primitive_assembler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] vertex_tag
   input  logic [5:0]  req_tuser,   // [1:0] operation, [5:2] prim_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] slot, [20:5] tag_out, [36:21] running_count
   output logic [5:0]  rsp_tuser,   // [1:0] status, [5:2] kind
   output logic        rsp_tlast
);

   logic [pa_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic                       ph_ff, ph_in;
   logic [pa_pkg::FILL_W-1:0]  cnt_ff, cnt_in;
   logic [pa_pkg::FILL_W-1:0]  lim_ff, lim_in;
   logic [pa_pkg::SLOT_AW-1:0] wr_addr_ff, wr_addr_in;
   logic [pa_pkg::TAG_W-1:0]   tag_ff, tag_in;
   logic [1:0]                 err_ff, err_in;
   logic                       open_ff, open_in;
   logic [3:0]                 mode_ff, mode_in;
   logic [pa_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [15:0]                total_ff, total_in;
   logic [pa_pkg::TAG_W-1:0]   rdata_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 out_status_ff, out_status_in;
   logic [3:0]                 out_kind_ff, out_kind_in;
   logic [pa_pkg::SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [pa_pkg::TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic [15:0]                out_count_ff, out_count_in;
   logic                       out_last_ff, out_last_in;

   logic [pa_pkg::TAG_W-1:0]   mem [pa_pkg::SLOT_DEPTH];
   logic                       mem_we, mem_re;
   logic [pa_pkg::SLOT_AW-1:0] mem_waddr, mem_raddr;
   logic [pa_pkg::TAG_W-1:0]   mem_wdata;

   pa_pkg::ctl_type            ctl;
   logic                       req_accept, out_free, adv, load;
   logic [1:0]                 op;
   logic [3:0]                 pt;
   logic [pa_pkg::FILL_W-1:0]  n_fill, cnt_nx;
   logic [15:0]                tot_inc;

   assign req_tready = (pc_ff == pa_pkg::PC_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign op         = req_tuser[1:0];
   assign pt         = req_tuser[5:2];
   assign ctl        = pa_pkg::rom_word(pc_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign n_fill     = fill_ff + pa_pkg::FILL_W'(1);
   assign cnt_nx     = cnt_ff + pa_pkg::FILL_W'(1);
   assign tot_inc    = (total_ff != 16'hFFFF) ? total_ff + 16'd1 : total_ff;

   always_comb begin
      pc_in         = pc_ff;
      ph_in         = ph_ff;
      cnt_in        = cnt_ff;
      lim_in        = lim_ff;
      wr_addr_in    = wr_addr_ff;
      tag_in        = tag_ff;
      err_in        = err_ff;
      open_in       = open_ff;
      mode_in       = mode_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_tag_in    = out_tag_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = wr_addr_ff;
      mem_raddr     = ctl.addr;
      mem_wdata     = tag_ff;
      adv           = 1'b0;
      load          = 1'b0;

      if (pc_ff == pa_pkg::PC_IDLE) begin
         if (req_accept) begin
            tag_in     = req_tdata;
            wr_addr_in = pa_pkg::SLOT_AW'(fill_ff);
            cnt_in     = '0;
            ph_in      = 1'b0;
            unique case (op)
               pa_pkg::OP_BEGIN: begin
                  if (open_ff || (pt > pa_pkg::MODE_POLYGON)) begin
                     err_in = pa_pkg::ST_SEQ;
                     pc_in  = pa_pkg::PC_ERR;
                  end else begin
                     open_in  = 1'b1;
                     mode_in  = pt;
                     fill_in  = '0;
                     total_in = '0;
                  end
               end
               pa_pkg::OP_VERTEX: begin
                  if (!open_ff) begin
                     err_in = pa_pkg::ST_SEQ;
                     pc_in  = pa_pkg::PC_ERR;
                  end else if ((mode_ff == pa_pkg::MODE_POLYGON) &&
                               (fill_ff >= pa_pkg::FILL_W'(pa_pkg::POLY_CAP))) begin
                     err_in = pa_pkg::ST_OVF;
                     pc_in  = pa_pkg::PC_ERR;
                  end else begin
                     total_in = tot_inc;
                     fill_in  = n_fill;
                     pc_in    = pa_pkg::PC_VO;
                     unique case (mode_ff) inside
                        pa_pkg::MODE_POINTS: begin
                           pc_in   = pa_pkg::PC_VR;
                           lim_in  = pa_pkg::FILL_W'(1);
                           fill_in = '0;
                        end
                        pa_pkg::MODE_LINES: begin
                           if (n_fill == pa_pkg::FILL_W'(2)) begin
                              pc_in   = pa_pkg::PC_VR;
                              lim_in  = pa_pkg::FILL_W'(2);
                              fill_in = '0;
                           end
                        end
                        pa_pkg::MODE_LSTRIP, pa_pkg::MODE_LOOP: begin
                           if (n_fill == pa_pkg::FILL_W'(1)) begin
                              pc_in = pa_pkg::PC_LF;
                           end else if (n_fill == pa_pkg::FILL_W'(2)) begin
                              pc_in   = pa_pkg::PC_LS;
                              lim_in  = pa_pkg::FILL_W'(2);
                              fill_in = pa_pkg::FILL_W'(1);
                           end
                        end
                        pa_pkg::MODE_TRIS: begin
                           if (n_fill == pa_pkg::FILL_W'(3)) begin
                              pc_in   = pa_pkg::PC_VR;
                              lim_in  = pa_pkg::FILL_W'(3);
                              fill_in = '0;
                           end
                        end
                        pa_pkg::MODE_TSTRIP: begin
                           if (n_fill == pa_pkg::FILL_W'(3)) begin
                              fill_in = '0;
                           end
                           if (tot_inc >= 16'd3) begin
                              pc_in  = pa_pkg::PC_VR;
                              lim_in = pa_pkg::FILL_W'(3);
                           end
                        end
                        pa_pkg::MODE_FAN: begin
                           if (n_fill == pa_pkg::FILL_W'(3)) begin
                              pc_in   = pa_pkg::PC_FAN;
                              lim_in  = pa_pkg::FILL_W'(3);
                              fill_in = pa_pkg::FILL_W'(2);
                           end
                        end
                        pa_pkg::MODE_QUADS: begin
                           if (n_fill == pa_pkg::FILL_W'(4)) begin
                              pc_in   = pa_pkg::PC_VR;
                              lim_in  = pa_pkg::FILL_W'(4);
                              fill_in = '0;
                           end
                        end
                        pa_pkg::MODE_QSTRIP: begin
                           if (n_fill == pa_pkg::FILL_W'(4)) begin
                              pc_in   = pa_pkg::PC_QS;
                              lim_in  = pa_pkg::FILL_W'(4);
                              fill_in = pa_pkg::FILL_W'(2);
                           end
                        end
                        default: begin
                           pc_in = pa_pkg::PC_VO;
                        end
                     endcase
                  end
               end
               pa_pkg::OP_END: begin
                  if (!open_ff) begin
                     err_in = pa_pkg::ST_SEQ;
                     pc_in  = pa_pkg::PC_ERR;
                  end else begin
                     open_in = 1'b0;
                     if ((mode_ff == pa_pkg::MODE_LOOP) && (total_ff >= 16'd3)) begin
                        pc_in = pa_pkg::PC_LE;
                     end else if ((mode_ff == pa_pkg::MODE_POLYGON) &&
                                  (fill_ff >= pa_pkg::FILL_W'(3))) begin
                        pc_in  = pa_pkg::PC_PE;
                        lim_in = fill_ff;
                     end
                  end
               end
               default: begin
                  err_in = pa_pkg::ST_SEQ;
                  pc_in  = pa_pkg::PC_ERR;
               end
            endcase
         end
      end else begin
         unique case (ctl.act)
            pa_pkg::ACT_ERR: begin
               if (out_free) begin
                  load          = 1'b1;
                  out_status_in = err_ff;
                  out_slot_in   = '0;
                  out_tag_in    = '0;
                  out_last_in   = 1'b1;
                  adv           = 1'b1;
               end
            end
            pa_pkg::ACT_WRTAG: begin
               mem_we = 1'b1;
               adv    = 1'b1;
            end
            pa_pkg::ACT_RD: begin
               mem_re = 1'b1;
               adv    = 1'b1;
            end
            pa_pkg::ACT_WR: begin
               mem_we    = 1'b1;
               mem_waddr = ctl.addr;
               mem_wdata = rdata_ff;
               adv       = 1'b1;
            end
            pa_pkg::ACT_RUN: begin
               if (!ph_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = pa_pkg::SLOT_AW'(cnt_ff);
                  ph_in     = 1'b1;
               end else if (out_free) begin
                  load          = 1'b1;
                  out_status_in = pa_pkg::ST_OK;
                  out_slot_in   = cnt_ff[pa_pkg::SLOT_W-1:0];
                  out_tag_in    = rdata_ff;
                  out_last_in   = (cnt_nx == lim_ff);
                  cnt_in        = cnt_nx;
                  ph_in         = 1'b0;
                  adv           = (cnt_nx == lim_ff);
               end
            end
            pa_pkg::ACT_ONE: begin
               if (!ph_ff) begin
                  mem_re = 1'b1;
                  ph_in  = 1'b1;
               end else if (out_free) begin
                  load          = 1'b1;
                  out_status_in = pa_pkg::ST_OK;
                  out_slot_in   = pa_pkg::SLOT_W'(ctl.addr);
                  out_tag_in    = rdata_ff;
                  out_last_in   = ctl.last;
                  ph_in         = 1'b0;
                  adv           = 1'b1;
               end
            end
            default: begin
               pc_in = pa_pkg::PC_IDLE;
            end
         endcase
         if (adv) begin
            pc_in = ctl.fin ? pa_pkg::PC_IDLE : pc_ff + pa_pkg::PC_W'(1);
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         out_kind_in  = mode_ff;
         out_count_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= pa_pkg::PC_IDLE;
         ph_ff        <= 1'b0;
         open_ff      <= 1'b0;
         mode_ff      <= pa_pkg::MODE_POINTS;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         ph_ff        <= ph_in;
         open_ff      <= open_in;
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      lim_ff        <= lim_in;
      wr_addr_ff    <= wr_addr_in;
      tag_ff        <= tag_in;
      err_ff        <= err_in;
      out_status_ff <= out_status_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_tag_ff    <= out_tag_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_count_ff, out_tag_ff, out_slot_ff};
   assign rsp_tuser  = {out_kind_ff, out_status_ff};
   assign rsp_tlast  = out_last_ff;

   `AST_IMPL(a_err_single, clock, reset, rsp_tvalid && (out_status_ff != pa_pkg::ST_OK), rsp_tlast && (out_slot_ff == '0) && (out_tag_ff == '0), "error transaction not a single zeroed beat")
   `AST_IMPL(a_fill_bound, clock, reset, open_ff && (mode_ff != pa_pkg::MODE_POLYGON), fill_ff <= pa_pkg::FILL_W'(3), "fill level out of range for mode")
   `AST_IMPL(a_run_bound, clock, reset, (pc_ff != pa_pkg::PC_IDLE) && (ctl.act == pa_pkg::ACT_RUN), cnt_ff < lim_ff, "emit index past run length")
   `AST_NEXT(a_rsvd_err, clock, reset, req_accept && (op == pa_pkg::OP_RSVD), pc_ff == pa_pkg::PC_ERR, "reserved operation did not raise error")

endmodule
